/* hw/rtl/dqr_pkg.sv */
package dqr_pkg;

	localparam int CURV_WIDTH_DEF = 32;
	localparam int STEP_WIDTH = 16;
	localparam logic [STEP_WIDTH-1:0] MAX_STEPS_RESET = '1;

	typedef struct packed {
		logic load;
		logic sel;
		logic move;
		logic publish;
	} dqr_cmd_t;

	typedef struct packed {
		logic steps_zero;
		logic go_on;
	} dqr_stat_t;

endpackage

/* hw/rtl/dqr_if.sv */
interface dqr_in_if import dqr_pkg::*; #(
	parameter int CURV_WIDTH = CURV_WIDTH_DEF
) ();
	logic valid;
	logic ready;
	logic signed [CURV_WIDTH-1:0] curv_a;
	logic signed [CURV_WIDTH-1:0] curv_b;
	logic signed [CURV_WIDTH-1:0] curv_c;
	logic signed [CURV_WIDTH-1:0] curv_d;

	modport source (output valid, output curv_a, output curv_b, output curv_c,
		output curv_d, input ready);
	modport sink (input valid, input curv_a, input curv_b, input curv_c,
		input curv_d, output ready);
endinterface

interface dqr_out_if import dqr_pkg::*; #(
	parameter int CURV_WIDTH = CURV_WIDTH_DEF
) ();
	logic valid;
	logic ready;
	logic signed [CURV_WIDTH-1:0] red_a;
	logic signed [CURV_WIDTH-1:0] red_b;
	logic signed [CURV_WIDTH-1:0] red_c;
	logic signed [CURV_WIDTH-1:0] red_d;
	logic [STEP_WIDTH-1:0] moves_kept;
	logic limit_reached;

	modport source (output valid, output red_a, output red_b, output red_c,
		output red_d, output moves_kept, output limit_reached, input ready);
	modport sink (input valid, input red_a, input red_b, input red_c,
		input red_d, input moves_kept, input limit_reached, output ready);
endinterface

interface dqr_cfg_if import dqr_pkg::*; ();
	logic valid;
	logic ready;
	logic [STEP_WIDTH-1:0] max_steps;

	modport source (output valid, output max_steps, input ready);
	modport sink (input valid, input max_steps, output ready);
endinterface

/* hw/rtl/dqr_ctrl.sv */
module dqr_ctrl import dqr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  dqr_stat_t stat,
	output dqr_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEL,
		ST_MOVE,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd         = '0;
		in_ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SEL: begin
				cmd.sel = 1'b1;
			end
			ST_MOVE: begin
				cmd.move = 1'b1;
			end
			ST_FIN: begin
				cmd.publish = !out_valid_q || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= stat.steps_zero ? ST_FIN : ST_SEL;
					end
				end
				ST_SEL: begin
					state_q <= ST_MOVE;
				end
				ST_MOVE: begin
					state_q <= stat.go_on ? ST_SEL : ST_FIN;
				end
				ST_FIN: begin
					if (cmd.publish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/dqr_dp.sv */
module dqr_dp import dqr_pkg::*; #(
	parameter int CURV_WIDTH = CURV_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [CURV_WIDTH-1:0] curv_a,
	input  logic signed [CURV_WIDTH-1:0] curv_b,
	input  logic signed [CURV_WIDTH-1:0] curv_c,
	input  logic signed [CURV_WIDTH-1:0] curv_d,
	input  logic                         cfg_we,
	input  logic [STEP_WIDTH-1:0]        cfg_max_steps,
	input  dqr_cmd_t                     cmd,
	output dqr_stat_t                    stat,
	output logic signed [CURV_WIDTH-1:0] red_a,
	output logic signed [CURV_WIDTH-1:0] red_b,
	output logic signed [CURV_WIDTH-1:0] red_c,
	output logic signed [CURV_WIDTH-1:0] red_d,
	output logic [STEP_WIDTH-1:0]        moves_kept,
	output logic                         limit_reached
);

	localparam int SW = CURV_WIDTH + 2;
	localparam int FW = CURV_WIDTH + 4;

	logic signed [CURV_WIDTH-1:0] q_q [4];
	logic [1:0]                   k_q;
	logic signed [SW-1:0]         sum_q;
	logic [STEP_WIDTH-1:0]        kept_q;
	logic                         limit_q;
	logic [STEP_WIDTH-1:0]        max_steps_q;

	logic [1:0]                   kmax;
	logic signed [CURV_WIDTH-1:0] kval;
	logic signed [SW-1:0]         sum;
	logic signed [CURV_WIDTH-1:0] qk;
	logic signed [FW-1:0]         qk_x;
	logic signed [FW-1:0]         sum_x;
	logic signed [FW-1:0]         fresh;
	logic signed [FW-1:0]         cmin_x;
	logic signed [CURV_WIDTH-1:0] fresh_sat;
	logic                         decrease;
	logic [STEP_WIDTH-1:0]        kept_inc;
	logic                         last;

	// The first position wins a tie, so only a strictly larger value moves the pick.
	always_comb begin
		kmax = 2'd0;
		kval = q_q[0];
		if (q_q[1] > kval) begin
			kmax = 2'd1;
			kval = q_q[1];
		end
		if (q_q[2] > kval) begin
			kmax = 2'd2;
			kval = q_q[2];
		end
		if (q_q[3] > kval) begin
			kmax = 2'd3;
			kval = q_q[3];
		end
	end

	assign sum = {{2{q_q[0][CURV_WIDTH-1]}}, q_q[0]} + {{2{q_q[1][CURV_WIDTH-1]}}, q_q[1]}
		+ {{2{q_q[2][CURV_WIDTH-1]}}, q_q[2]} + {{2{q_q[3][CURV_WIDTH-1]}}, q_q[3]};

	// Twice the other three minus the old value is twice the total minus three times it.
	assign qk     = q_q[k_q];
	assign qk_x   = {{4{qk[CURV_WIDTH-1]}}, qk};
	assign sum_x  = {{2{sum_q[SW-1]}}, sum_q};
	assign fresh  = (sum_x <<< 1) - qk_x - (qk_x <<< 1);
	assign cmin_x = {{5{1'b1}}, {(CURV_WIDTH-1){1'b0}}};

	assign decrease  = fresh < qk_x;
	assign fresh_sat = (fresh < cmin_x) ? cmin_x[CURV_WIDTH-1:0] : fresh[CURV_WIDTH-1:0];
	assign kept_inc  = kept_q + {{(STEP_WIDTH-1){1'b0}}, 1'b1};
	assign last      = kept_inc == max_steps_q;

	assign stat.steps_zero = max_steps_q == '0;
	assign stat.go_on      = decrease && !last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_steps_q <= MAX_STEPS_RESET;
		end else if (cfg_we) begin
			max_steps_q <= cfg_max_steps;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			q_q[0]  <= curv_a;
			q_q[1]  <= curv_b;
			q_q[2]  <= curv_c;
			q_q[3]  <= curv_d;
			kept_q  <= '0;
			limit_q <= 1'b0;
		end
		if (cmd.sel) begin
			k_q   <= kmax;
			sum_q <= sum;
		end
		if (cmd.move && decrease) begin
			q_q[k_q] <= fresh_sat;
			kept_q   <= kept_inc;
			limit_q  <= last;
		end
		if (cmd.publish) begin
			red_a         <= q_q[0];
			red_b         <= q_q[1];
			red_c         <= q_q[2];
			red_d         <= q_q[3];
			moves_kept    <= kept_q;
			limit_reached <= limit_q;
		end
	end

endmodule

/* hw/rtl/descartes_quadruple_reduce_top.sv */
// Reduces a quadruple of signed curvatures toward its root quadruple.
// The curv channel takes one word of four curvatures; the red channel returns
// one word with the reduced curvatures, the number of moves kept and a flag
// that is set when reduction stopped at the step limit.
// The cfg channel writes the step limit; it is always ready and should only
// be written while the block is idle. A limit of zero returns the input as is.
// Each move has two steps: the SEL state picks the largest entry and totals the
// four values, and the MOVE state forms and tests the replacement value. Moves
// go on while the replacement is smaller than the old value and the step limit
// is not yet reached, and one word is worked on at a time.
// The result sits in an output register, so a new word is taken while the
// previous result still waits; if the receiver stalls for longer than the
// next word's work, the finished result is held until the register is free.
// Reset clears the control logic, empties the output register and sets the
// step limit to its largest value.
module descartes_quadruple_reduce_top import dqr_pkg::*; #(
	parameter int CURV_WIDTH = CURV_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	dqr_in_if.sink    curv,
	dqr_out_if.source red,
	dqr_cfg_if.sink   cfg
);

	dqr_cmd_t  cmd;
	dqr_stat_t stat;

	assign cfg.ready = 1'b1;

	dqr_ctrl u_dqr_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (curv.valid),
		.in_ready  (curv.ready),
		.out_valid (red.valid),
		.out_ready (red.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dqr_dp #(
		.CURV_WIDTH (CURV_WIDTH)
	) u_dqr_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.curv_a        (curv.curv_a),
		.curv_b        (curv.curv_b),
		.curv_c        (curv.curv_c),
		.curv_d        (curv.curv_d),
		.cfg_we        (cfg.valid && cfg.ready),
		.cfg_max_steps (cfg.max_steps),
		.cmd           (cmd),
		.stat          (stat),
		.red_a         (red.red_a),
		.red_b         (red.red_b),
		.red_c         (red.red_c),
		.red_d         (red.red_d),
		.moves_kept    (red.moves_kept),
		.limit_reached (red.limit_reached)
	);

endmodule

/* hw/rtl/dqr_checker.sv */
module dqr_checker import dqr_pkg::*; #(
	parameter int CURV_WIDTH = CURV_WIDTH_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [CURV_WIDTH-1:0] red_a,
	input logic [CURV_WIDTH-1:0] red_b,
	input logic [CURV_WIDTH-1:0] red_c,
	input logic [CURV_WIDTH-1:0] red_d,
	input logic [STEP_WIDTH-1:0] moves_kept,
	input logic                  limit_reached
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Result word withdrawn while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(red_a) && $stable(red_b) && $stable(red_c)
			&& $stable(red_d) && $stable(moves_kept) && $stable(limit_reached))
		else $error("Result word changed while stalled.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Input taken again before the word was reduced.");

	a_limit_needs_moves: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && limit_reached |-> moves_kept != '0)
		else $error("Limit flag set with no moves kept.");

endmodule

bind descartes_quadruple_reduce_top dqr_checker #(
	.CURV_WIDTH (CURV_WIDTH)
) u_dqr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (curv.valid),
	.in_ready      (curv.ready),
	.out_valid     (red.valid),
	.out_ready     (red.ready),
	.red_a         (red.red_a),
	.red_b         (red.red_b),
	.red_c         (red.red_c),
	.red_d         (red.red_d),
	.moves_kept    (red.moves_kept),
	.limit_reached (red.limit_reached)
);
